// ===== hw/rtl/wnpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wnpd_pkg
// shared types and constants of the nearest point distance block
// ----------------------------------------------------------------------------
package wnpd_pkg;

  localparam int COORD_W = 20;
  localparam int POINT_W = 2 * COORD_W;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int DIST_W  = 21;
  localparam int COUNT_W = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ROOT
  } state_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } dist_ctl_t;

endpackage

// ===== hw/rtl/wnpd_store.sv =====
// ----------------------------------------------------------------------------
// wnpd_store
// feature point memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module wnpd_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  wnpd_pkg::point_t           wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output wnpd_pkg::point_t           rd_data
);

  logic [wnpd_pkg::POINT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= wnpd_pkg::point_t'(mem[rd_addr]);
    end
  end

endmodule

// ===== hw/rtl/wnpd_dist.sv =====
// ----------------------------------------------------------------------------
// wnpd_dist
// squared distance of each streamed point and running minimum
// ----------------------------------------------------------------------------
module wnpd_dist (
  input  logic                              clk,
  input  logic                              rst,
  input  wnpd_pkg::dist_ctl_t               ctl,
  input  wnpd_pkg::point_t                  point,
  input  logic [wnpd_pkg::COORD_W-1:0]      qx,
  input  logic [wnpd_pkg::COORD_W-1:0]      qy,
  output logic                              busy,
  output logic [wnpd_pkg::SQ_W-1:0]         best
);

  logic [wnpd_pkg::COORD_W-1:0]   dx;
  logic [wnpd_pkg::COORD_W-1:0]   dy;
  logic [2*wnpd_pkg::COORD_W-1:0] sqx;
  logic [2*wnpd_pkg::COORD_W-1:0] sqy;
  logic                           sq_vld;
  logic [wnpd_pkg::SQ_W-1:0]      sum;

  assign dx  = (point.x >= qx) ? point.x - qx : qx - point.x;
  assign dy  = (point.y >= qy) ? point.y - qy : qy - point.y;
  assign sum = {1'b0, sqx} + {1'b0, sqy};
  assign busy = sq_vld;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= ctl.vld && !ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      sqx <= dx * dx;
      sqy <= dy * dy;
    end
  end

  // add and keep the minimum
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best <= '1;
    end else if (sq_vld && sum < best) begin
      best <= sum;
    end
  end

  a_clear_on_empty_pipe: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |-> !sq_vld && !ctl.vld)
    else $error("minimum cleared while squares still in flight");

  a_best_never_rises: assert property (@(posedge clk) disable iff (rst)
    !ctl.clear |=> best <= $past(best))
    else $error("running minimum grew without a clear");

endmodule

// ===== hw/rtl/wnpd_sqrt.sv =====
// ----------------------------------------------------------------------------
// wnpd_sqrt
// iterative floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module wnpd_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [wnpd_pkg::SQ_W-1:0]         radicand,
  output logic                              done,
  output logic [wnpd_pkg::DIST_W-1:0]       root
);

  localparam int SH_W  = 2 * wnpd_pkg::DIST_W;
  localparam int REM_W = wnpd_pkg::DIST_W + 1;
  localparam int CNT_W = $clog2(wnpd_pkg::DIST_W + 1);

  logic [SH_W-1:0]  shreg;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W:0]   rem_sh;
  logic [REM_W:0]   trial;
  logic             take;

  assign rem_sh = {rem[REM_W-2:0], shreg[SH_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(wnpd_pkg::DIST_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= SH_W'(radicand);
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      shreg <= {shreg[SH_W-3:0], 2'b00};
      rem   <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root  <= {root[wnpd_pkg::DIST_W-2:0], take};
    end
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("square root restarted mid-iteration");

endmodule

// ===== hw/rtl/worley_nearest_point_distance.sv =====
// ----------------------------------------------------------------------------
// worley_nearest_point_distance
// worley f1 noise: distance from a query coordinate to the nearest stored point
// ----------------------------------------------------------------------------
//  channel   ports                                          handshake
//  item      cmd entry_index coord_x coord_y                start & !busy
//  result    distance empty_set                             done, one cycle
//  config    cfg_data (point_count)                         cfg_valid & cfg_ready
//
//  a load gives no result; busy stays low
//  a query over n points keeps busy high through the scan, one memory read
//  a cycle, the pipeline drain and the square root (21 iterations and its
//  done register); done follows on the next cycle
//  a query with no points in use answers on the next cycle without going busy
//  rst clears the control state; store contents stay undefined until loaded
//  the receiver cannot stall, done is a one cycle strobe
module worley_nearest_point_distance #(
  parameter int MAX_POINTS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [7:0]                        entry_index,
  input  logic [wnpd_pkg::COORD_W-1:0]      coord_x,
  input  logic [wnpd_pkg::COORD_W-1:0]      coord_y,
  output logic                              done,
  output logic [wnpd_pkg::DIST_W-1:0]       distance,
  output logic                              empty_set,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wnpd_pkg::COUNT_W-1:0]      cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = (AW > 8) ? AW : 8;

  wnpd_pkg::state_t             state;
  wnpd_pkg::state_t             state_next;
  logic [wnpd_pkg::COUNT_W-1:0] point_count;
  logic [CW-1:0]                used_reg;
  logic [CW-1:0]                used_now;
  logic [CW-1:0]                scan_cnt;
  logic [CW-1:0]                scan_cnt_next;
  logic [wnpd_pkg::COORD_W-1:0] qx;
  logic [wnpd_pkg::COORD_W-1:0] qy;
  logic                         rd_vld;
  logic                         rd_en;
  logic                         wr_en;
  logic [IW-1:0]                slot_ext;
  wnpd_pkg::point_t             wr_point;
  wnpd_pkg::point_t             rd_point;
  wnpd_pkg::dist_ctl_t          dctl;
  logic                         dist_busy;
  logic [wnpd_pkg::SQ_W-1:0]    best;
  logic                         sq_start;
  logic                         sq_done;
  logic [wnpd_pkg::DIST_W-1:0]  sq_root;
  logic                         accept;
  logic                         query_go;
  logic                         res_empty;
  logic                         res_root;

  assign busy      = state != wnpd_pkg::S_IDLE;
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign slot_ext  = IW'(entry_index);
  assign used_now  = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign wr_point  = '{y: coord_y, x: coord_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= wnpd_pkg::S_IDLE;
      scan_cnt <= '0;
      rd_vld   <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      rd_vld   <= rd_en;
      done     <= res_empty || res_root;
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      used_reg <= used_now;
      qx       <= coord_x;
      qy       <= coord_y;
    end
    if (res_empty) begin
      distance  <= wnpd_pkg::DIST_MAX;
      empty_set <= 1'b1;
    end else if (res_root) begin
      distance  <= sq_root;
      empty_set <= 1'b0;
    end
  end

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    query_go      = 1'b0;
    res_empty     = 1'b0;
    res_root      = 1'b0;
    sq_start      = 1'b0;
    dctl.clear    = 1'b0;
    dctl.vld      = rd_vld;
    case (state)
      wnpd_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd == wnpd_pkg::CMD_QUERY) begin
            if (used_now == '0) begin
              res_empty = 1'b1;
            end else begin
              query_go      = 1'b1;
              dctl.clear    = 1'b1;
              scan_cnt_next = '0;
              state_next    = wnpd_pkg::S_SCAN;
            end
          end else begin
            wr_en = 32'(entry_index) < MAX_POINTS;
          end
        end
      end
      wnpd_pkg::S_SCAN: begin
        rd_en         = 1'b1;
        scan_cnt_next = scan_cnt + 1'b1;
        if (CW'(scan_cnt + 1'b1) == used_reg) begin
          state_next = wnpd_pkg::S_DRAIN;
        end
      end
      wnpd_pkg::S_DRAIN: begin
        if (!rd_vld && !dist_busy) begin
          sq_start   = 1'b1;
          state_next = wnpd_pkg::S_ROOT;
        end
      end
      wnpd_pkg::S_ROOT: begin
        if (sq_done) begin
          res_root   = 1'b1;
          state_next = wnpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wnpd_pkg::S_IDLE;
      end
    endcase
  end

  wnpd_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_data (wr_point),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt[AW-1:0]),
    .rd_data (rd_point)
  );

  wnpd_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .ctl   (dctl),
    .point (rd_point),
    .qx    (qx),
    .qy    (qy),
    .busy  (dist_busy),
    .best  (best)
  );

  wnpd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (best),
    .done     (sq_done),
    .root     (sq_root)
  );

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == wnpd_pkg::S_SCAN |-> scan_cnt < used_reg)
    else $error("scan address past the points in use");

  a_empty_flag_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> empty_set == (distance == wnpd_pkg::DIST_MAX))
    else $error("empty flag disagrees with distance");

endmodule

// ===== tb/sv/nearest_distance_checker.sv =====
// ----------------------------------------------------------------------------
// nearest_distance_checker
// watches the item, config and result channels of the nearest point distance
// block, keeps its own point store and point count, predicts the answer of
// each accepted query and compares it with the next done strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nearest_distance_checker #(
  parameter int MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cmd,
  input  logic [7:0]                    entry_index,
  input  logic [wnpd_pkg::COORD_W-1:0]  coord_x,
  input  logic [wnpd_pkg::COORD_W-1:0]  coord_y,
  input  logic                          done,
  input  logic [wnpd_pkg::DIST_W-1:0]   distance,
  input  logic                          empty_set,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wnpd_pkg::COUNT_W-1:0]  cfg_data,
  output int                            mismatch_count,
  output int                            outstanding
);

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [wnpd_pkg::DIST_W-1:0] dist_val;
    logic                        empty_set;
  } answer_t;

  wnpd_pkg::point_t              point_mem [MAX_POINTS];
  logic [wnpd_pkg::COUNT_W-1:0]  points_in_use;
  answer_t                       expected_answers [$];
  int                            fails;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    fails          = 0;
    points_in_use  = '0;
  end

  // bit-serial integer square root, floor
  function automatic logic [wnpd_pkg::DIST_W-1:0] floor_root(input logic [63:0] value);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] weight;
    rem    = value;
    root   = '0;
    weight = 64'd1 << 62;
    while (weight > rem) weight = weight >> 2;
    while (weight != 0) begin
      if (rem >= root + weight) begin
        rem  = rem - (root + weight);
        root = (root >> 1) + weight;
      end else begin
        root = root >> 1;
      end
      weight = weight >> 2;
    end
    return root[wnpd_pkg::DIST_W-1:0];
  endfunction

  function automatic answer_t nearest_distance(input logic [wnpd_pkg::COORD_W-1:0] qx,
                                               input logic [wnpd_pkg::COORD_W-1:0] qy);
    logic [63:0] best;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] sq;
    int          used;
    answer_t     ans;
    used = (points_in_use > MAX_POINTS) ? MAX_POINTS : int'(points_in_use);
    if (used == 0) begin
      ans.dist_val  = wnpd_pkg::DIST_MAX;
      ans.empty_set = 1'b1;
      return ans;
    end
    best = '1;
    for (int i = 0; i < used; i++) begin
      dx = (point_mem[i].x >= qx) ? 64'(point_mem[i].x - qx)
                                  : 64'(qx - point_mem[i].x);
      dy = (point_mem[i].y >= qy) ? 64'(point_mem[i].y - qy)
                                  : 64'(qy - point_mem[i].y);
      sq = dx * dx + dy * dy;
      if (sq < best) best = sq;
    end
    ans.dist_val  = floor_root(best);
    ans.empty_set = 1'b0;
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      expected_answers.delete();
      points_in_use = '0;
      for (int i = 0; i < MAX_POINTS; i++) point_mem[i] = '0;
    end else begin
      if (done) begin
        if (expected_answers.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result with no query waiting: expected none, got %h empty_set %b",
                     $time, distance, empty_set);
        end else begin
          want = expected_answers.pop_front();
          if (distance !== want.dist_val) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: distance expected %h got %h", $time, want.dist_val, distance);
          end
          if (empty_set !== want.empty_set) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: empty_set expected %b got %b", $time, want.empty_set,
                       empty_set);
          end
        end
      end
      if (start && !busy) begin
        if (cmd == wnpd_pkg::CMD_LOAD) begin
          if (entry_index < MAX_POINTS)
            point_mem[entry_index] = '{y: coord_y, x: coord_x};
        end else begin
          expected_answers.push_back(nearest_distance(coord_x, coord_y));
        end
      end
      // a count written on the same edge applies from the next query on
      if (cfg_valid && cfg_ready) points_in_use = cfg_data;
    end
    outstanding    <= expected_answers.size();
    mismatch_count <= fails;
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the worley f1 nearest point distance block: directed corner
// queries, a full store load, then random phases over several point counts
// and idle patterns; the checker beside the block does the comparing
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int MAX_POINTS      = 256;
  localparam int LIMIT_CYCLES    = 1_000_000;
  localparam int ITEMS_PER_PHASE = 38;
  localparam int NUM_PHASES      = 10;
  localparam int IDLE_NONE       = 0;
  localparam int IDLE_SENDER     = 1;
  localparam int IDLE_LIGHT      = 2;
  localparam logic [wnpd_pkg::COORD_W-1:0] COORD_MAX = '1;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          cmd;
  logic [7:0]                    entry_index;
  logic [wnpd_pkg::COORD_W-1:0]  coord_x;
  logic [wnpd_pkg::COORD_W-1:0]  coord_y;
  logic                          done;
  logic [wnpd_pkg::DIST_W-1:0]   distance;
  logic                          empty_set;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [wnpd_pkg::COUNT_W-1:0]  cfg_data;
  int                            mismatch_count;
  int                            outstanding;
  int                            cycle_count;

  logic [wnpd_pkg::COORD_W-1:0]  shadow_x [MAX_POINTS];
  logic [wnpd_pkg::COORD_W-1:0]  shadow_y [MAX_POINTS];
  int                            count_now;
  int                            phase_count [NUM_PHASES] = '{1, 2, 5, 16, 0, 256, 3, 40, 511, 9};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  worley_nearest_point_distance u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .entry_index (entry_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .done        (done),
    .distance    (distance),
    .empty_set   (empty_set),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  nearest_distance_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .done           (done),
    .distance       (distance),
    .empty_set      (empty_set),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  function automatic logic [wnpd_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COORD_MAX;
      2: return wnpd_pkg::COORD_W'($urandom_range(0, 255));
      3: return COORD_MAX - wnpd_pkg::COORD_W'($urandom_range(0, 255));
      default: return wnpd_pkg::COORD_W'($urandom());
    endcase
  endfunction

  // returns right after the accepting edge; start is left high
  task automatic send_item(input logic c, input logic [7:0] idx,
                           input logic [wnpd_pkg::COORD_W-1:0] x,
                           input logic [wnpd_pkg::COORD_W-1:0] y);
    start       <= 1'b1;
    cmd         <= c;
    entry_index <= idx;
    coord_x     <= x;
    coord_y     <= y;
    do @(posedge clk); while (busy);
    if (c == wnpd_pkg::CMD_LOAD) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
    end
  endtask

  task automatic after_beat(input int mode);
    int chance;
    int gap;
    chance = (mode == IDLE_SENDER) ? 47 : (mode == IDLE_LIGHT) ? 11 : 0;
    if ($urandom_range(0, 99) < chance) begin
      // long gaps land inside the scan and the root of the query just sent
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // loads give no answer and never go busy, so a short pause after the last answer is enough
  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_point_count(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= wnpd_pkg::COUNT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_now = value;
  endtask

  task automatic random_item();
    int                            used;
    int                            k;
    logic [wnpd_pkg::COORD_W-1:0]  qx;
    logic [wnpd_pkg::COORD_W-1:0]  qy;
    used = (count_now > MAX_POINTS) ? MAX_POINTS : count_now;
    if ($urandom_range(0, 9) < 3) begin
      k = (used > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, used - 1)
                                                  : $urandom_range(0, MAX_POINTS - 1);
      send_item(wnpd_pkg::CMD_LOAD, 8'(k), rand_coord(), rand_coord());
    end else if (used > 0 && $urandom_range(0, 2) == 0) begin
      // query close to a point in use
      k  = $urandom_range(0, used - 1);
      qx = shadow_x[k] + wnpd_pkg::COORD_W'($urandom_range(0, 64)) - wnpd_pkg::COORD_W'(32);
      qy = shadow_y[k] + wnpd_pkg::COORD_W'($urandom_range(0, 64)) - wnpd_pkg::COORD_W'(32);
      send_item(wnpd_pkg::CMD_QUERY, 8'($urandom()), qx, qy);
    end else begin
      send_item(wnpd_pkg::CMD_QUERY, 8'($urandom()), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("worley_nearest_point_distance: mismatch");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = wnpd_pkg::CMD_LOAD;
    entry_index = '0;
    coord_x     = '0;
    coord_y     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    count_now   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty set right after reset
    send_item(wnpd_pkg::CMD_QUERY, 8'h00, '0, '0);
    send_item(wnpd_pkg::CMD_QUERY, 8'hFF, COORD_MAX, COORD_MAX);
    // corner points, both ends of the slot index
    send_item(wnpd_pkg::CMD_LOAD, 8'd0, '0, '0);
    send_item(wnpd_pkg::CMD_LOAD, 8'd255, COORD_MAX, COORD_MAX);
    send_item(wnpd_pkg::CMD_LOAD, 8'd1, COORD_MAX, COORD_MAX);
    send_item(wnpd_pkg::CMD_LOAD, 8'd2, COORD_MAX, '0);
    send_item(wnpd_pkg::CMD_LOAD, 8'd3, '0, COORD_MAX);
    start <= 1'b0;
    settle();

    // single point at the origin: largest distance, exact hit, 3-4-5
    write_point_count(1);
    send_item(wnpd_pkg::CMD_QUERY, 8'h00, COORD_MAX, COORD_MAX);
    send_item(wnpd_pkg::CMD_QUERY, 8'hFF, '0, '0);
    send_item(wnpd_pkg::CMD_QUERY, 8'h5A, 20'd3, 20'd4);
    start <= 1'b0;
    settle();

    // four corners: near tie in the middle, off-by-one and non-square distances
    write_point_count(4);
    send_item(wnpd_pkg::CMD_QUERY, 8'hA5, COORD_MAX >> 1, COORD_MAX >> 1);
    send_item(wnpd_pkg::CMD_QUERY, 8'h00, COORD_MAX, 20'd1);
    send_item(wnpd_pkg::CMD_QUERY, 8'hFF, 20'd2, COORD_MAX - 20'd3);
    send_item(wnpd_pkg::CMD_QUERY, 8'h33, COORD_MAX, '0);
    start <= 1'b0;

    // fill the whole store so every count can be used
    for (int i = 0; i < MAX_POINTS; i++) begin
      send_item(wnpd_pkg::CMD_LOAD, 8'(i), rand_coord(), rand_coord());
      after_beat(IDLE_SENDER);
    end
    start <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_point_count(phase_count[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_item();
        after_beat(p % 3);
      end
      start <= 1'b0;
    end

    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("worley_nearest_point_distance: match");
    else
      $display("worley_nearest_point_distance: mismatch");
    $finish;
  end

endmodule
